// ===== src/float32_multiply_truncating_macros.svh =====
// Assertion macros shared by the multiplier checker.
`ifndef FLOAT32_MULTIPLY_TRUNCATING_MACROS_SVH
`define FLOAT32_MULTIPLY_TRUNCATING_MACROS_SVH

// cond must never hold while out of reset
`define F32MT_ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("f32mt: property violated");

// cons must hold at the delay n after ante
`define F32MT_ASSERT_AFTER(label, ante, n, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error("f32mt: property violated");

`endif

// ===== src/f32mt_pkg.sv =====
// Types and constants of the truncating single-precision multiplier.
package f32mt_pkg;

	localparam int WORD_W        = 32;
	localparam int EXP_W         = 8;
	localparam int FRAC_W        = 23;
	localparam int MANT_W        = FRAC_W + 1;
	localparam int PROD_W        = 2 * MANT_W;
	localparam int EXP_SUM_W     = EXP_W + 2;
	localparam int NUM_CELLS_DEF = 4;

	localparam logic [EXP_SUM_W-1:0] EXP_BIAS    = EXP_SUM_W'(127);
	localparam logic [WORD_W-1:0]    ONE_PATTERN = 32'h3F80_0000;

	typedef logic signed [EXP_SUM_W-1:0] expo_t;

	typedef struct packed {
		logic [WORD_W-1:0] operand_a;
		logic [WORD_W-1:0] operand_b;
	} in_t;

	typedef struct packed {
		logic [WORD_W-1:0] product;
		logic              exponent_range_flag;
	} out_t;

	// Word handed from cell to cell along the multiplier chain.
	typedef struct packed {
		logic              valid;
		logic              bypass;
		logic [WORD_W-1:0] word;
		logic              sign;
		expo_t             expo;
		logic [MANT_W-1:0] ma;
		logic [MANT_W-1:0] mb;
		logic [PROD_W-1:0] acc;
	} cell_t;

endpackage

// ===== src/f32mt_decode.sv =====
// Input stage: special-case decode, sign and exponent sum, chain seed.
module f32mt_decode (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  f32mt_pkg::in_t  operands,
	output f32mt_pkg::cell_t seed
);
	import f32mt_pkg::*;

	logic [WORD_W-1:0] a, b;
	logic [EXP_W-1:0]  ea, eb;
	logic              byp;
	logic [WORD_W-1:0] byp_word;
	cell_t             seed_s1;

	assign a  = operands.operand_a;
	assign b  = operands.operand_b;
	assign ea = a[WORD_W-2 -: EXP_W];
	assign eb = b[WORD_W-2 -: EXP_W];

	// priority: zero, a is one, b is one, denormal
	always_comb begin
		byp      = 1'b1;
		byp_word = '0;
		if (a[WORD_W-2:0] == '0 || b[WORD_W-2:0] == '0) begin
			byp_word = '0;
		end else if (a == ONE_PATTERN) begin
			byp_word = b;
		end else if (b == ONE_PATTERN) begin
			byp_word = a;
		end else if (ea == '0 || eb == '0) begin
			byp_word = '0;
		end else begin
			byp = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_s1 <= '0;
		end else begin
			seed_s1.valid  <= take;
			seed_s1.bypass <= byp;
			seed_s1.word   <= byp_word;
			seed_s1.sign   <= a[WORD_W-1] ^ b[WORD_W-1];
			seed_s1.expo   <= expo_t'(EXP_SUM_W'(ea) + EXP_SUM_W'(eb) - EXP_BIAS);
			seed_s1.ma     <= {1'b1, a[FRAC_W-1:0]};
			seed_s1.mb     <= {1'b1, b[FRAC_W-1:0]};
			seed_s1.acc    <= '0;
		end
	end

	assign seed = seed_s1;

endmodule

// ===== src/f32mt_cell.sv =====
// One multiplier cell: adds one digit of the second mantissa into the product.
module f32mt_cell #(
	parameter int DIGIT_W = 6,
	parameter int IDX     = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  f32mt_pkg::cell_t din,
	output f32mt_pkg::cell_t dout
);
	import f32mt_pkg::*;

	localparam int SHIFT = IDX * DIGIT_W;

	logic [DIGIT_W-1:0]        digit;
	logic [MANT_W+DIGIT_W-1:0] pp;
	logic [PROD_W-1:0]         acc_next;
	cell_t                     dout_q;

	assign digit    = din.mb[DIGIT_W-1:0];
	assign pp       = (MANT_W+DIGIT_W)'(din.ma) * (MANT_W+DIGIT_W)'(digit);
	assign acc_next = din.acc + (PROD_W'(pp) << SHIFT);

	// pass the rest along; retire the consumed digit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout_q <= '0;
		end else begin
			dout_q.valid  <= din.valid;
			dout_q.bypass <= din.bypass;
			dout_q.word   <= din.word;
			dout_q.sign   <= din.sign;
			dout_q.expo   <= din.expo;
			dout_q.ma     <= din.ma;
			dout_q.mb     <= din.mb >> DIGIT_W;
			dout_q.acc    <= acc_next;
		end
	end

	assign dout = dout_q;

endmodule

// ===== src/f32mt_norm.sv =====
// Output stage: one-step normalize, truncate, exponent wrap and range flag.
module f32mt_norm (
	input  logic             clk,
	input  logic             arst_n,
	input  f32mt_pkg::cell_t din,
	output logic             strobe,
	output f32mt_pkg::out_t  result
);
	import f32mt_pkg::*;

	logic [FRAC_W-1:0] frac;
	expo_t             expo_n;
	logic              flag;
	logic              strobe_q;
	out_t              result_q;

	always_comb begin
		if (din.acc[PROD_W-1]) begin
			frac   = din.acc[PROD_W-2 -: FRAC_W];
			expo_n = din.expo + expo_t'(1);
		end else begin
			frac   = din.acc[PROD_W-3 -: FRAC_W];
			expo_n = din.expo;
		end
		flag = (expo_n < expo_t'(1)) || (expo_n > expo_t'(254));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din.bypass) begin
			result_q.product             <= din.word;
			result_q.exponent_range_flag <= 1'b0;
		end else begin
			result_q.product             <= {din.sign, expo_n[EXP_W-1:0], frac};
			result_q.exponent_range_flag <= flag;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

// ===== src/float32_multiply_truncating.sv =====
// Top level of the truncating single-precision multiplier.
// Stages: one decode stage, one stage per multiplier cell, one normalize stage.
// Throughput: one word per cycle; busy stays low and the result strobe cannot be stalled.
// Each cell adds one ceil(24 / NUM_CELLS)-bit digit of the second mantissa.
// Reset: arst_n clears every stage valid bit at once; no word is in flight after reset.
module float32_multiply_truncating #(
	parameter int NUM_CELLS = f32mt_pkg::NUM_CELLS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  f32mt_pkg::in_t  operands,
	output logic            strobe,
	output f32mt_pkg::out_t result
);
	import f32mt_pkg::*;

	localparam int DIGIT_W = (MANT_W + NUM_CELLS - 1) / NUM_CELLS;

	cell_t chain [NUM_CELLS+1];

	assign busy = 1'b0;

	f32mt_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (start && !busy),
		.operands (operands),
		.seed     (chain[0])
	);

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		f32mt_cell #(
			.DIGIT_W (DIGIT_W),
			.IDX     (i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.din    (chain[i]),
			.dout   (chain[i+1])
		);
	end

	f32mt_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (chain[NUM_CELLS]),
		.strobe (strobe),
		.result (result)
	);

endmodule

// ===== src/f32mt_checker.sv =====
// Port-level checker for the multiplier and its bind to the top level.
`include "float32_multiply_truncating_macros.svh"

module f32mt_checker #(
	parameter int LATENCY = f32mt_pkg::NUM_CELLS_DEF + 2
) (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input f32mt_pkg::in_t  operands,
	input logic            strobe,
	input f32mt_pkg::out_t result
);
	import f32mt_pkg::*;

	`F32MT_ASSERT_NEVER(a_never_busy, busy)
	`F32MT_ASSERT_AFTER(a_word_out, start && !busy, LATENCY, strobe)
	`F32MT_ASSERT_AFTER(a_no_stray_out, !(start && !busy), LATENCY, !strobe)
	`F32MT_ASSERT_AFTER(a_zero_operand, start && !busy && (operands.operand_a[WORD_W-2:0] == '0 || operands.operand_b[WORD_W-2:0] == '0), LATENCY, result.product == '0 && !result.exponent_range_flag)
	`F32MT_ASSERT_AFTER(a_one_passes, start && !busy && operands.operand_a == ONE_PATTERN && operands.operand_b[WORD_W-2:0] != '0, LATENCY, result.product == $past(operands.operand_b, LATENCY))

endmodule

bind float32_multiply_truncating f32mt_checker #(.LATENCY(NUM_CELLS + 2)) u_f32mt_checker (.*);
